[design/fmld_pkg.sv]
// fmld_pkg: shared types, register indexes, reset values and state codes
// for the frequency monitor; used by every module in design/
`timescale 1ns / 1ps
`default_nettype none

package fmld_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int CFG_ADDR_W  = 3;

  localparam logic [15:0] RST_TARGET_HZ       = 16'd100;
  localparam logic [15:0] RST_TOLERANCE_HZ    = 16'd5;
  localparam logic [31:0] RST_TIMER_CLOCK_HZ  = 32'd100000;
  localparam logic [15:0] RST_TIMEOUT_MS      = 16'd100;
  localparam logic [31:0] RST_EVAL_INTERVAL   = 32'd1000;
  localparam logic [15:0] RST_BAD_LIMIT       = 16'd100;
  localparam logic [15:0] BAD_COUNT_MAX       = 16'hFFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET_FREQ = 3'd0,
    REG_TOLERANCE   = 3'd1,
    REG_TIMER_CLOCK = 3'd2,
    REG_TIMEOUT     = 3'd3,
    REG_EVAL_INTERVAL = 3'd4,
    REG_BAD_LIMIT   = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_EXEC = 3'd1,
    ST_DIV  = 3'd2,
    ST_EVAL = 3'd3,
    ST_DONE = 3'd4
  } back_state_t;

  typedef struct packed {
    logic [15:0] target_hz;
    logic [15:0] tolerance_hz;
    logic [31:0] timer_clock_hz;
    logic [15:0] timeout_ms;
    logic [31:0] eval_interval_counts;
    logic [15:0] bad_limit;
  } cfg_t;

  typedef struct packed {
    kind_t                  kind;
    logic [COUNT_WIDTH-1:0] count;
    logic [31:0]            now_ms;
    logic [31:0]            next_cmp;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_ctl_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_sts_t;

endpackage

`default_nettype wire

[design/fmld_front.sv]
// fmld_front: takes input requests, classifies them and forms a command
// with the next compare value; depends on fmld_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmld_front (
  input  wire logic              in_push,
  input  wire logic              in_kind,
  input  wire logic [31:0]       in_capture_count,
  input  wire logic [31:0]       in_now_ms,
  input  wire logic [31:0]       in_counter_now,
  input  wire logic [31:0]       eval_interval_counts,
  input  wire logic              q_full,
  output logic                   q_push,
  output fmld_pkg::cmd_t         q_cmd
);

  logic [fmld_pkg::COUNT_WIDTH-1:0] next_cnt;

  assign next_cnt = in_counter_now[fmld_pkg::COUNT_WIDTH-1:0]
                  + eval_interval_counts[fmld_pkg::COUNT_WIDTH-1:0];

  always_comb begin
    q_cmd.kind     = fmld_pkg::kind_t'(in_kind);
    q_cmd.count    = in_capture_count[fmld_pkg::COUNT_WIDTH-1:0];
    q_cmd.now_ms   = in_now_ms;
    q_cmd.next_cmp = 32'(next_cnt);
  end

  assign q_push = in_push & ~q_full;

endmodule

`default_nettype wire

[design/fmld_queue.sv]
// fmld_queue: two-entry command queue between front and back
// depends on fmld_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmld_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire fmld_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output fmld_pkg::cmd_t      head
);

  fmld_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = cnt_r[1];
  assign valid   = (cnt_r != 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

[design/fmld_div.sv]
// fmld_div: radix-2 restoring divider, one quotient bit per cycle
// depends on fmld_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmld_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fmld_pkg::div_ctl_t ctl,
  output fmld_pkg::div_sts_t    sts
);

  logic [31:0]                   q_r, q_nxt;
  logic [31:0]                   rem_r, rem_nxt;
  logic [31:0]                   d_r, d_nxt;
  logic [fmld_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [32:0]                   trial;

  assign trial = {rem_r, q_r[31]} - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      q_nxt    = ctl.dividend;
      rem_nxt  = 32'd0;
      d_nxt    = ctl.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + fmld_pkg::DIV_CNT_W'(1);
      if (cnt_r == fmld_pkg::DIV_CNT_W'(fmld_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign sts.done     = done_r;
  assign sts.quotient = q_r;

endmodule

`default_nettype wire

[design/fmld_back.sv]
// fmld_back: executes commands against the monitor state, drives the divider
// and holds the result register; depends on fmld_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmld_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fmld_pkg::cfg_t     cfg,
  input  wire logic               q_valid,
  input  wire fmld_pkg::cmd_t     q_head,
  output logic                    q_pop,
  output fmld_pkg::div_ctl_t      div_ctl,
  input  wire fmld_pkg::div_sts_t div_sts,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [31:0]             out_freq_hz,
  output logic                    out_signal_lost,
  output logic                    out_in_window,
  output logic [15:0]             out_bad_count,
  output logic                    out_stopped,
  output logic [31:0]             out_next_compare,
  output logic                    out_next_compare_valid
);

  fmld_pkg::back_state_t state_r, state_nxt;
  fmld_pkg::cmd_t        cmd_r, cmd_nxt;

  logic                             have_r, have_nxt;
  logic [fmld_pkg::COUNT_WIDTH-1:0] prev_r, prev_nxt;
  logic [31:0]                      meas_r, meas_nxt;
  logic [31:0]                      last_r, last_nxt;
  logic [15:0]                      bad_r, bad_nxt;
  logic                             halted_r, halted_nxt;

  logic lost_r, lost_nxt;
  logic ge_low_r, ge_low_nxt;
  logic le_high_r, le_high_nxt;
  logic res_lost_r, res_lost_nxt;
  logic res_inwin_r, res_inwin_nxt;
  logic res_valid_r, res_valid_nxt;

  logic out_v_r, out_v_nxt;
  logic out_free, out_load;

  logic [fmld_pkg::COUNT_WIDTH-1:0] diff;
  logic [31:0]                      elapsed;
  logic [15:0]                      win_low;
  logic [16:0]                      win_high;
  logic                             inwin;
  logic [15:0]                      bad_upd;

  assign out_free = ~out_v_r | out_pop;
  assign diff     = cmd_r.count - prev_r;
  assign elapsed  = cmd_r.now_ms - last_r;
  assign win_low  = (cfg.target_hz >= cfg.tolerance_hz)
                  ? cfg.target_hz - cfg.tolerance_hz : 16'd0;
  assign win_high = {1'b0, cfg.target_hz} + {1'b0, cfg.tolerance_hz};
  assign inwin    = ~lost_r & ge_low_r & le_high_r;
  assign bad_upd  = inwin ? 16'd0
                  : ((bad_r != fmld_pkg::BAD_COUNT_MAX) ? bad_r + 16'd1 : bad_r);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    have_nxt      = have_r;
    prev_nxt      = prev_r;
    meas_nxt      = meas_r;
    last_nxt      = last_r;
    bad_nxt       = bad_r;
    halted_nxt    = halted_r;
    lost_nxt      = lost_r;
    ge_low_nxt    = ge_low_r;
    le_high_nxt   = le_high_r;
    res_lost_nxt  = res_lost_r;
    res_inwin_nxt = res_inwin_r;
    res_valid_nxt = res_valid_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    div_ctl.start    = 1'b0;
    div_ctl.dividend = cfg.timer_clock_hz;
    div_ctl.divisor  = 32'(diff);
    case (state_r)
      fmld_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          state_nxt = fmld_pkg::ST_EXEC;
        end
      end
      fmld_pkg::ST_EXEC: begin
        res_lost_nxt  = 1'b0;
        res_inwin_nxt = 1'b0;
        res_valid_nxt = 1'b0;
        if (halted_r) begin
          state_nxt = fmld_pkg::ST_DONE;
        end else if (cmd_r.kind == fmld_pkg::KIND_EDGE) begin
          last_nxt = cmd_r.now_ms;
          prev_nxt = cmd_r.count;
          if (!have_r) begin
            have_nxt  = 1'b1;
            state_nxt = fmld_pkg::ST_DONE;
          end else if (diff == '0) begin
            meas_nxt  = 32'd0;
            have_nxt  = 1'b0;
            state_nxt = fmld_pkg::ST_DONE;
          end else begin
            div_ctl.start = 1'b1;
            state_nxt     = fmld_pkg::ST_DIV;
          end
        end else begin
          lost_nxt    = ~have_r | (elapsed > {16'd0, cfg.timeout_ms});
          ge_low_nxt  = (meas_r >= {16'd0, win_low});
          le_high_nxt = (meas_r <= {15'd0, win_high});
          state_nxt   = fmld_pkg::ST_EVAL;
        end
      end
      fmld_pkg::ST_DIV: begin
        if (div_sts.done) begin
          meas_nxt  = div_sts.quotient;
          state_nxt = fmld_pkg::ST_DONE;
        end
      end
      fmld_pkg::ST_EVAL: begin
        if (lost_r) begin
          meas_nxt = 32'd0;
          have_nxt = 1'b0;
        end
        bad_nxt       = bad_upd;
        res_lost_nxt  = lost_r;
        res_inwin_nxt = inwin;
        if (bad_upd >= cfg.bad_limit) begin
          halted_nxt    = 1'b1;
          res_valid_nxt = 1'b0;
        end else begin
          res_valid_nxt = 1'b1;
        end
        state_nxt = fmld_pkg::ST_DONE;
      end
      fmld_pkg::ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = fmld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fmld_pkg::ST_IDLE;
      end
    endcase
    out_v_nxt = out_load ? 1'b1 : (out_pop ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmld_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      prev_r   <= '0;
      meas_r   <= 32'd0;
      last_r   <= 32'd0;
      bad_r    <= 16'd0;
      halted_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      have_r   <= have_nxt;
      prev_r   <= prev_nxt;
      meas_r   <= meas_nxt;
      last_r   <= last_nxt;
      bad_r    <= bad_nxt;
      halted_r <= halted_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    lost_r      <= lost_nxt;
    ge_low_r    <= ge_low_nxt;
    le_high_r   <= le_high_nxt;
    res_lost_r  <= res_lost_nxt;
    res_inwin_r <= res_inwin_nxt;
    res_valid_r <= res_valid_nxt;
    if (out_load) begin
      out_freq_hz            <= meas_r;
      out_signal_lost        <= res_lost_r;
      out_in_window          <= res_inwin_r;
      out_bad_count          <= bad_r;
      out_stopped            <= halted_r;
      out_next_compare       <= res_valid_r ? cmd_r.next_cmp : 32'd0;
      out_next_compare_valid <= res_valid_r;
    end
  end

  assign out_empty = ~out_v_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halted state cleared without reset");

  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == fmld_pkg::ST_IDLE))
    else $error("queue popped outside idle");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> (state_r == fmld_pkg::ST_EXEC) && !halted_r
                      && (cmd_r.kind == fmld_pkg::KIND_EDGE) && (diff != '0))
    else $error("divider started for a non-edge or zero period");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fmld_pkg::ST_DIV) && div_sts.done |=> (state_r == fmld_pkg::ST_DONE))
    else $error("divide result not taken");

  a_halt_no_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |-> !res_valid_r)
    else $error("compare value produced on halting evaluation");

endmodule

`default_nettype wire

[design/frequency_monitor_with_loss_detect.sv]
// frequency_monitor_with_loss_detect: top level, configuration registers and
// wiring of front, queue, divider and back; depends on fmld_pkg and all fmld_*
//
// usage
//   input channel: a request is taken when in_push is high and in_full low;
//   in_kind 0 is a capture edge, 1 an evaluation tick
//   result channel: exactly one result per request, in order; the oldest is
//   on out_* while out_empty is low and leaves when out_pop is high
//   config: cfg_we writes cfg_wdata into register cfg_addr;
//   write only while no request is in flight; unknown indexes are dropped
//   execution: an evaluation tick passes the queue and the IDLE, EXEC, EVAL
//   and DONE states before out_empty goes low; a first or repeated capture,
//   or any request once stopped, goes from EXEC straight to DONE; a capture
//   that needs a frequency waits in DIV for the 32-step serial divider
//   the back end executes one request at a time; a two-entry command queue
//   sits between input and execution, so requests are still taken while a
//   result waits; a stalled result stops execution and then fills the
//   queue, which raises in_full
//   reset: synchronous rst_n clears state, empties the result register and
//   queue, and loads the register defaults; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module frequency_monitor_with_loss_detect (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic                            in_kind,
  input  wire logic [31:0]                     in_capture_count,
  input  wire logic [31:0]                     in_now_ms,
  input  wire logic [31:0]                     in_counter_now,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [31:0]                          out_freq_hz,
  output logic                                 out_signal_lost,
  output logic                                 out_in_window,
  output logic [15:0]                          out_bad_count,
  output logic                                 out_stopped,
  output logic [31:0]                          out_next_compare,
  output logic                                 out_next_compare_valid,
  input  wire logic                            cfg_we,
  input  wire logic [fmld_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [31:0]                     cfg_wdata
);

  fmld_pkg::cfg_t     cfg_r, cfg_nxt;
  fmld_pkg::cmd_t     push_cmd;
  fmld_pkg::cmd_t     q_head;
  fmld_pkg::div_ctl_t div_ctl;
  fmld_pkg::div_sts_t div_sts;
  logic               q_push, q_pop, q_full, q_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        fmld_pkg::REG_TARGET_FREQ:   cfg_nxt.target_hz            = cfg_wdata[15:0];
        fmld_pkg::REG_TOLERANCE:     cfg_nxt.tolerance_hz         = cfg_wdata[15:0];
        fmld_pkg::REG_TIMER_CLOCK:   cfg_nxt.timer_clock_hz       = cfg_wdata;
        fmld_pkg::REG_TIMEOUT:       cfg_nxt.timeout_ms           = cfg_wdata[15:0];
        fmld_pkg::REG_EVAL_INTERVAL: cfg_nxt.eval_interval_counts = cfg_wdata;
        fmld_pkg::REG_BAD_LIMIT:     cfg_nxt.bad_limit            = cfg_wdata[15:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_hz            <= fmld_pkg::RST_TARGET_HZ;
      cfg_r.tolerance_hz         <= fmld_pkg::RST_TOLERANCE_HZ;
      cfg_r.timer_clock_hz       <= fmld_pkg::RST_TIMER_CLOCK_HZ;
      cfg_r.timeout_ms           <= fmld_pkg::RST_TIMEOUT_MS;
      cfg_r.eval_interval_counts <= fmld_pkg::RST_EVAL_INTERVAL;
      cfg_r.bad_limit            <= fmld_pkg::RST_BAD_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;

  fmld_front u_front (
    .in_push              (in_push),
    .in_kind              (in_kind),
    .in_capture_count     (in_capture_count),
    .in_now_ms            (in_now_ms),
    .in_counter_now       (in_counter_now),
    .eval_interval_counts (cfg_r.eval_interval_counts),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_cmd                (push_cmd)
  );

  fmld_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  fmld_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .sts   (div_sts)
  );

  fmld_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .q_valid                (q_valid),
    .q_head                 (q_head),
    .q_pop                  (q_pop),
    .div_ctl                (div_ctl),
    .div_sts                (div_sts),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_freq_hz            (out_freq_hz),
    .out_signal_lost        (out_signal_lost),
    .out_in_window          (out_in_window),
    .out_bad_count          (out_bad_count),
    .out_stopped            (out_stopped),
    .out_next_compare       (out_next_compare),
    .out_next_compare_valid (out_next_compare_valid)
  );

endmodule

`default_nettype wire
